FILE: hw/rtl/gzc_pkg.sv
// Shared types and constants for the grid zero-crossing marker.
package gzc_pkg;

  typedef logic [1:0] sign_t;

  localparam sign_t SGN_ZERO = 2'd0;
  localparam sign_t SGN_POS  = 2'd1;
  localparam sign_t SGN_NEG  = 2'd2;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_FIRST = 2'd0;
  localparam phase_t PH_RUN   = 2'd1;
  localparam phase_t PH_FLUSH = 2'd2;

  localparam int CFG_WIDTH_BITS = 11;
  localparam logic [CFG_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam logic [0:0] REG_ROW_WIDTH = 1'b0;

  // One line buffer entry: sign of the row above and of the middle row.
  typedef struct packed {
    sign_t above;
    sign_t middle;
  } lb_entry_t;

  typedef struct packed {
    lb_entry_t entry;
    sign_t     right_mid;
  } lb_rd_t;

  typedef struct packed {
    phase_t phase;
    sign_t  prev_cur;
    sign_t  mid_left;
  } gzc_state_t;

  typedef struct packed {
    logic valid;
    logic on_contour;
    logic row_end;
    logic frame_end;
  } gzc_res_t;

  typedef struct packed {
    gzc_state_t state_next;
    gzc_res_t   res;
    logic       lb_we;
    lb_entry_t  lb_wdata;
  } gzc_step_t;

  function automatic logic opposite(input sign_t a, input sign_t b);
    return ((a == SGN_POS) && (b == SGN_NEG)) || ((a == SGN_NEG) && (b == SGN_POS));
  endfunction

endpackage

FILE: hw/rtl/gzc_if.sv
// Stream interfaces for the pixel input and the contour mark output.
interface gzc_pixel_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          is_flush;

  modport source (output valid, output sample, output is_flush, input ready);
  modport sink   (input valid, input sample, input is_flush, output ready);
endinterface

interface gzc_mark_if;
  logic valid;
  logic ready;
  logic on_contour;
  logic row_end;
  logic frame_end;

  modport source (output valid, output on_contour, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input on_contour, input row_end, input frame_end,
                  output ready);
endinterface

FILE: hw/rtl/grid_zero_crossing_marker.sv
// Top level of the grid zero-crossing marker: input stage, pixel logic, result register.
//
//   channel   direction  transaction                        notes
//   pixels    in         sample, is_flush                   one pixel in raster order
//   marks     out        on_contour, row_end, frame_end     pixel one row behind
//   apb       in/out     row_width at byte address 0        write only while idle
//
// One pixel per cycle while marks.ready holds high; the result register loads a pixel's mark
// as the pixel steps out of the input stage. First-row pixels and ignored padding
// step through without loading a result.
// The line buffer is read ahead at the current and the next column, so the two
// registered read ports hold both entries ready when the pixel steps.
// Synchronous active-high reset clears the stages, column count and frame phase;
// line buffer contents stay undefined until written and need no clearing pass.
// A stalled output holds its result and one more pixel waits in the input stage;
// then pixels.ready drops, and the input stage refills as the result drains.
module grid_zero_crossing_marker
  import gzc_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  gzc_pixel_if.sink             pixels,
  gzc_mark_if.source            marks
);

  localparam int CB = $clog2(MAX_WIDTH);

  logic [CFG_WIDTH_BITS-1:0] row_width;

  // Input stage.
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_flush;

  // Frame state.
  gzc_state_t    st;
  logic [CB-1:0] col;

  gzc_step_t     step;
  logic [CB-1:0] step_col_next;
  logic [CB-1:0] col_next;
  lb_rd_t        rd;
  logic          advance;

  gzc_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_width (row_width)
  );

  // Step the held pixel once the result register is free or draining.
  assign advance      = in_valid && (!marks.valid || marks.ready);
  assign pixels.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixels.valid && pixels.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.valid && pixels.ready) begin
      in_sample <= pixels.sample;
      in_flush  <= pixels.is_flush;
    end
  end

  gzc_step #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CB          (CB)
  ) u_step (
    .st        (st),
    .col       (col),
    .row_width (row_width),
    .rd        (rd),
    .sample    (in_sample),
    .flush     (in_flush),
    .step      (step),
    .col_next  (step_col_next)
  );

  // Prefetch the column the next pixel lands on and its right neighbor.
  always_comb begin
    if (rst) begin
      col_next = '0;
    end else if (advance) begin
      col_next = step_col_next;
    end else begin
      col_next = col;
    end
  end

  gzc_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AB    (CB)
  ) u_line_buf (
    .clk    (clk),
    .we     (advance && step.lb_we),
    .waddr  (col),
    .wdata  (step.lb_wdata),
    .raddr0 (col_next),
    .raddr1 (col_next + CB'(1)),
    .rd     (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '{phase: PH_FIRST, prev_cur: SGN_ZERO, mid_left: SGN_ZERO};
      col <= '0;
    end else if (advance) begin
      st  <= step.state_next;
      col <= step_col_next;
    end
  end

  // Result register: load on a producing step, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      marks.valid <= 1'b0;
    end else if (advance && step.res.valid) begin
      marks.valid <= 1'b1;
    end else if (marks.ready) begin
      marks.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.res.valid) begin
      marks.on_contour <= step.res.on_contour;
      marks.row_end    <= step.res.row_end;
      marks.frame_end  <= step.res.frame_end;
    end
  end

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    marks.valid && marks.frame_end |-> marks.row_end)
    else $error("frame end without row end");

  a_row_end_wraps_col: assert property (@(posedge clk) disable iff (rst)
    advance && step.res.valid && step.res.row_end |=> (col == '0))
    else $error("column did not wrap after row end");

  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    advance && (st.phase == PH_FIRST) |-> !step.res.valid)
    else $error("result produced during first row");

  a_frame_end_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && step.res.frame_end |=> (st.phase == PH_FIRST))
    else $error("frame end did not restart the frame");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> in_valid && marks.valid)
    else $error("input stalled with nothing held");

endmodule

FILE: hw/rtl/gzc_apb_regs.sv
// APB configuration register holding the row width.
module gzc_apb_regs
  import gzc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_BITS-1:0]     paddr,
  input  logic [PDATA_BITS-1:0]     pwdata,
  output logic [PDATA_BITS-1:0]     prdata,
  output logic                      pready,
  output logic [CFG_WIDTH_BITS-1:0] row_width
);

  logic       wr_en;
  logic [0:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (wr_en && (reg_idx == REG_ROW_WIDTH)) begin
      row_width <= pwdata[CFG_WIDTH_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_WIDTH: prdata = PDATA_BITS'(row_width);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/gzc_line_buf.sv
// Line buffer of sign pairs: one write port, two registered read ports with bypass.
module gzc_line_buf
  import gzc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AB    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AB-1:0] waddr,
  input  lb_entry_t     wdata,
  input  logic [AB-1:0] raddr0,
  input  logic [AB-1:0] raddr1,
  output lb_rd_t        rd
);

  lb_entry_t mem [DEPTH];
  lb_entry_t rd0_entry;
  sign_t     rd1_mid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Forward a same-cycle write so the next column always sees fresh data.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr0)) begin
      rd0_entry <= wdata;
    end else begin
      rd0_entry <= mem[raddr0];
    end
    if (we && (waddr == raddr1)) begin
      rd1_mid <= wdata.middle;
    end else begin
      rd1_mid <= mem[raddr1].middle;
    end
  end

  assign rd = '{entry: rd0_entry, right_mid: rd1_mid};

endmodule

FILE: hw/rtl/gzc_step.sv
// Sign test and next-state logic for one pixel.
module gzc_step
  import gzc_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int CB          = 10
) (
  input  gzc_state_t                    st,
  input  logic [CB-1:0]                 col,
  input  logic [CFG_WIDTH_BITS-1:0]     row_width,
  input  lb_rd_t                        rd,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          flush,
  output gzc_step_t                     step,
  output logic [CB-1:0]                 col_next
);

  localparam int WB = (CB + 1 > CFG_WIDTH_BITS) ? CB + 1 : CFG_WIDTH_BITS;

  logic [WB-1:0] w_ext;
  logic [WB-1:0] w_eff;
  logic          last;
  logic          not_first_col;
  sign_t         cur;
  sign_t         mid;
  sign_t         up;
  phase_t        phase_eff;
  logic          mark;
  logic          fend;

  // Clamp the width into 1..MAX_WIDTH.
  always_comb begin
    w_ext = WB'(row_width);
    if (w_ext == '0) begin
      w_eff = WB'(1);
    end else if (w_ext > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
  end

  assign last          = (WB'(col) + WB'(1)) >= w_eff;
  assign not_first_col = (col != '0);
  assign mid           = rd.entry.middle;
  assign up            = rd.entry.above;

  always_comb begin
    if (sample == '0) begin
      cur = SGN_ZERO;
    end else if (sample[SAMPLE_BITS-1]) begin
      cur = SGN_NEG;
    end else begin
      cur = SGN_POS;
    end
  end

  always_comb begin
    step          = '0;
    step.state_next = st;
    step.lb_wdata = '{above: SGN_ZERO, middle: cur};
    col_next      = col;
    phase_eff     = st.phase;
    mark          = 1'b0;
    fend          = 1'b0;
    if ((st.phase != PH_RUN) && (st.phase != PH_FLUSH)) begin
      // First row: store signs (padding is skipped), no row above, no result.
      if (!flush) begin
        step.lb_we = 1'b1;
        if (last) begin
          col_next                 = '0;
          step.state_next.phase    = PH_RUN;
          step.state_next.prev_cur = SGN_ZERO;
          step.state_next.mid_left = SGN_ZERO;
        end else begin
          col_next = col + CB'(1);
        end
      end
    end else begin
      if ((st.phase == PH_RUN) && flush) begin
        phase_eff = PH_FLUSH;
      end
      mark = (mid == SGN_ZERO)
          || (not_first_col && opposite(mid, st.mid_left))
          || opposite(mid, up)
          || (!last && opposite(rd.right_mid, mid));
      if (phase_eff == PH_RUN) begin
        // The row below claims this pixel unless its left test already fired.
        if ((cur != SGN_ZERO) && !(not_first_col && opposite(cur, st.prev_cur))
            && opposite(cur, mid)) begin
          mark = 1'b1;
        end
        step.lb_we               = 1'b1;
        step.lb_wdata            = '{above: mid, middle: cur};
        step.state_next.prev_cur = cur;
      end
      step.state_next.mid_left = mid;
      step.state_next.phase    = phase_eff;
      if (last) begin
        col_next = '0;
        if (phase_eff == PH_FLUSH) begin
          step.state_next.phase = PH_FIRST;
          fend                  = 1'b1;
        end
      end else begin
        col_next = col + CB'(1);
      end
      step.res = '{valid: 1'b1, on_contour: mark, row_end: last, frame_end: fend};
    end
  end

endmodule
